// File: sv/bmf_pkg.sv
`timescale 1ns / 1ps
// Shared types and fixed widths of the box mean filter.
package bmf_pkg;

    localparam int unsigned CSUM_W = 12;  // column sum width
    localparam int unsigned WSUM_W = 16;  // window sum width
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned POS_W  = 10;  // width of reported centre coordinates
    localparam int unsigned CFG_W  = 11;  // widest configuration register

    typedef enum logic [1:0] {
        REG_WINDOW_SIZE  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2,
        REG_NONE         = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_RD1,
        S_RD2,
        S_WS,
        S_DIV,
        S_OUT
    } t_state;

endpackage

// File: sv/bmf_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle.
module bmf_div import bmf_pkg::*; #(
    parameter int unsigned DVW = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WSUM_W-1:0] i_dividend,
    input  logic [DVW-1:0]    i_divisor,
    output logic              o_done,
    output logic [WSUM_W-1:0] o_quotient,
    output logic [DVW-1:0]    o_remainder
);

    localparam int unsigned CNT_W = $clog2(WSUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVW-1:0]    r_rem;
    logic [WSUM_W-1:0] r_quo;
    logic [DVW-1:0]    r_dvs;
    logic [DVW:0]      shifted;
    logic              fits;

    always_comb begin
        shifted = {r_rem, r_quo[WSUM_W-1]};
        fits    = (shifted >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(WSUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DVW'(shifted - {1'b0, r_dvs}) : shifted[DVW-1:0];
            r_quo <= {r_quo[WSUM_W-2:0], fits};
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// File: sv/box_mean_filter.sv
`timescale 1ns / 1ps
// Box mean filter top level: line store, column sums and sequencer.
// The filter takes one pixel at a time and holds o_in_stall high until that
// pixel is done. A pixel passes through the store and column-sum accesses,
// then the divider that forms the mean and the output register load when it
// completes a full window; the first pixel of a row also needs row mod N
// (the slot is cached for the rest of the row). Its pace is set by the shared
// bit-serial divider and the single read port of the column-sum memory. The
// finished result sits in an output register, so the next pixel is taken
// while it waits. The line store and column sums need no clearing pass.
module box_mean_filter import bmf_pkg::*; #(
    parameter int unsigned MAX_WIDTH  = 1024,
    parameter int unsigned MAX_HEIGHT = 1024,
    parameter int unsigned MAX_WINDOW = 15
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [7:0]       i_pixel,
    input  logic             i_frame_start,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_mean_value,
    output logic [9:0]       o_center_row,
    output logic [9:0]       o_center_col
);

    localparam int unsigned CW   = $clog2(MAX_WIDTH);
    localparam int unsigned CW1  = $clog2(MAX_WIDTH + 1);
    localparam int unsigned RW   = $clog2(MAX_HEIGHT);
    localparam int unsigned RW1  = $clog2(MAX_HEIGHT + 1);
    localparam int unsigned NW   = $clog2(MAX_WINDOW + 1);
    localparam int unsigned SW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int unsigned DVW  = 2 * NW;
    localparam int unsigned DEPTH = MAX_WINDOW * MAX_WIDTH;
    localparam int unsigned AW   = $clog2(DEPTH);

    // configuration
    logic [3:0]       r_win;
    logic [CFG_W-1:0] r_width;
    logic [CFG_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win    <= 4'd3;
            r_width  <= CFG_W'(640);
            r_height <= CFG_W'(480);
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_WINDOW_SIZE:  r_win    <= i_cfg_data[3:0];
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [NW-1:0]  n;
    logic [CW1-1:0] w;
    logic [RW1-1:0] h;

    always_comb begin
        if (r_win == 4'd0) n = NW'(1);
        else if (32'(r_win) > MAX_WINDOW) n = NW'(MAX_WINDOW);
        else n = NW'(r_win);
        if (r_width == '0) w = CW1'(1);
        else if (32'(r_width) > MAX_WIDTH) w = CW1'(MAX_WIDTH);
        else w = CW1'(r_width);
        if (r_height == '0) h = RW1'(1);
        else if (32'(r_height) > MAX_HEIGHT) h = RW1'(MAX_HEIGHT);
        else h = RW1'(r_height);
    end

    // memories
    logic [PIX_W-1:0]  row_mem [DEPTH];
    logic [CSUM_W-1:0] col_mem [MAX_WIDTH];
    logic [PIX_W-1:0]  r_row_rd;
    logic [CSUM_W-1:0] r_col_rd;

    // sequencer state
    t_state            r_state, n_state;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [RW-1:0]     r_r;
    logic [CW-1:0]     r_c;
    logic [PIX_W-1:0]  r_p;
    logic [SW-1:0]     r_slot;
    logic [RW-1:0]     r_slot_row;
    logic [NW-1:0]     r_slot_n;
    logic              r_slot_ok;
    logic [CSUM_W-1:0] r_cs;
    logic [WSUM_W-1:0] r_wsum;
    logic              r_out_valid;
    logic [7:0]        r_mean;
    logic [9:0]        r_crow;
    logic [9:0]        r_ccol;

    logic              accept;
    logic [RW1-1:0]    acc_row;
    logic [CW-1:0]     acc_col;
    logic              slot_hit;
    logic [CSUM_W-1:0] cs_calc;
    logic [WSUM_W-1:0] ws_calc;
    logic              produce;
    logic [CW1-1:0]    c_next;
    logic [RW1-1:0]    r_next;
    logic              out_free;
    logic [AW-1:0]     row_addr;
    logic [CW-1:0]     col_rd_addr;

    logic              div_start;
    logic [WSUM_W-1:0] div_dividend;
    logic [DVW-1:0]    div_divisor;
    logic              div_done;
    logic [WSUM_W-1:0] div_quo;
    logic [DVW-1:0]    div_rem;

    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    // position of the incoming pixel
    always_comb begin
        acc_row = i_frame_start ? '0 : RW1'(r_row);
        acc_col = i_frame_start ? '0 : r_col;
        if (CW1'(acc_col) >= w) begin
            acc_col = '0;
            acc_row = acc_row + 1'b1;
        end
        if (acc_row >= h) acc_row = '0;
    end

    assign slot_hit = r_slot_ok && (r_slot_row == acc_row[RW-1:0]) && (r_slot_n == n);
    assign row_addr = AW'(r_slot) * AW'(MAX_WIDTH) + AW'(r_c);
    assign col_rd_addr = (r_state == S_RD2) ? (r_c - CW'(n)) : r_c;

    always_comb begin
        if (r_r == '0) cs_calc = CSUM_W'(r_p);
        else if (RW1'(r_r) < RW1'(n)) cs_calc = r_col_rd + CSUM_W'(r_p);
        else cs_calc = r_col_rd + CSUM_W'(r_p) - CSUM_W'(r_row_rd);

        if (r_c == '0) ws_calc = WSUM_W'(r_cs);
        else if (CW1'(r_c) < CW1'(n)) ws_calc = r_wsum + WSUM_W'(r_cs);
        else ws_calc = r_wsum + WSUM_W'(r_cs) - WSUM_W'(r_col_rd);

        produce = (RW1'(r_r) + 1'b1 >= RW1'(n)) && (CW1'(r_c) + 1'b1 >= CW1'(n));
        c_next  = CW1'(r_c) + 1'b1;
        r_next  = RW1'(r_r) + 1'b1;
    end

    // memory ports
    always_ff @(posedge i_clk) begin
        r_row_rd <= row_mem[row_addr];
        r_col_rd <= col_mem[col_rd_addr];
        if (r_state == S_RD2) begin
            row_mem[row_addr] <= r_p;
            col_mem[r_c]      <= cs_calc;
        end
    end

    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = WSUM_W'(r_r);
        div_divisor  = DVW'(n);
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = slot_hit ? S_RD1 : S_MOD;
                if (accept && !slot_hit) begin
                    div_start    = 1'b1;
                    div_dividend = WSUM_W'(acc_row[RW-1:0]);
                end
            end
            S_MOD:  if (div_done) n_state = S_RD1;
            S_RD1:  n_state = S_RD2;
            S_RD2:  n_state = S_WS;
            S_WS: begin
                if (produce) begin
                    div_start    = 1'b1;
                    div_dividend = ws_calc;
                    div_divisor  = DVW'(n) * DVW'(n);
                    n_state      = S_DIV;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV:  if (div_done) n_state = S_OUT;
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row       <= '0;
            r_col       <= '0;
            r_slot_ok   <= 1'b0;
            r_wsum      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
            if (r_state == S_MOD && div_done) r_slot_ok <= 1'b1;
            if (r_state == S_WS) begin
                r_wsum <= ws_calc;
                // advance to the next pixel position
                if (c_next >= w) begin
                    r_col <= '0;
                    r_row <= (r_next >= h) ? '0 : r_next[RW-1:0];
                end else begin
                    r_col <= c_next[CW-1:0];
                    r_row <= r_r;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_r <= acc_row[RW-1:0];
            r_c <= acc_col;
            r_p <= i_pixel;
        end
        if (r_state == S_MOD && div_done) begin
            r_slot     <= div_rem[SW-1:0];
            r_slot_row <= r_r;
            r_slot_n   <= n;
        end
        if (r_state == S_RD2) r_cs <= cs_calc;
        if (r_state == S_OUT && out_free) begin
            r_mean <= div_quo[7:0];
            r_crow <= POS_W'(RW1'(r_r) + 1'b1 - RW1'(n) + RW1'(n >> 1));
            r_ccol <= POS_W'(CW1'(r_c) + 1'b1 - CW1'(n) + CW1'(n >> 1));
        end
    end

    bmf_div #(
        .DVW(DVW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_mean_value = r_mean;
    assign o_center_row = r_crow;
    assign o_center_col = r_ccol;

endmodule

// File: sv/bmf_checker.sv
`timescale 1ns / 1ps
// Port-level checks of the box mean filter, bound to the top level.
module bmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_mean_value,
    input logic [9:0] o_center_row,
    input logic [9:0] o_center_col
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mean_value)
            && $stable(o_center_row) && $stable(o_center_col))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second request taken while one is in work");

    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no request in work");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("outputs not cleared by reset");

endmodule

bind box_mean_filter bmf_checker u_bmf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_stall   (o_in_stall),
    .o_out_valid  (o_out_valid),
    .i_out_stall  (i_out_stall),
    .o_mean_value (o_mean_value),
    .o_center_row (o_center_row),
    .o_center_col (o_center_col)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of the box mean filter: directed table, then random frames.
module tb;
    import bmf_pkg::*;

    typedef struct packed {
        logic [7:0] mean;
        logic [9:0] row;
        logic [9:0] col;
    } t_window_out;

    typedef struct {
        logic [7:0]  pixel;
        logic        fs;
        logic        typed;
        t_window_out res;
    } t_dir_row;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int DRAIN_CYCLES = 80;
    localparam int DIR_SPLIT    = 11;
    localparam int DIR_ROWS     = 20;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_we = 1'b0;
    logic [1:0]       i_cfg_idx = REG_NONE;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic             i_in_valid = 1'b0;
    logic             o_in_stall;
    logic [7:0]       i_pixel = '0;
    logic             i_frame_start = 1'b0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    logic [7:0]       o_mean_value;
    logic [9:0]       o_center_row;
    logic [9:0]       o_center_col;

    box_mean_filter dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // filter model state
    logic [7:0]  line_pix [0:15*1024-1];
    logic [11:0] col_sum [0:1023];
    logic [15:0] win_sum;
    int unsigned cur_row, cur_col;
    int unsigned win_reg, width_reg, height_reg;

    t_window_out pending_means[$];
    int          fail_count;
    int          send_idle_pct, stall_pct;
    int          hold_left;
    int          items_sent;
    int          cycle_count;
    logic        force_fs;

    function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    // advance the filter model by one pixel; returns 1 with a window mean
    function automatic logic filter_pixel(logic [7:0] p, logic fs, output t_window_out res);
        int unsigned n, w, h, r, c, slot, cs, mean;
        n = clamp_to(win_reg, 15);
        w = clamp_to(width_reg, 1024);
        h = clamp_to(height_reg, 1024);
        res = '0;
        if (fs) begin
            cur_row = 0;
            cur_col = 0;
        end
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= h) cur_row = 0;
        r = cur_row;
        c = cur_col;
        slot = r % n;
        if (r == 0) cs = p;
        else if (r < n) cs = col_sum[c] + p;
        else cs = col_sum[c] + p - line_pix[slot*1024 + c];
        cs = cs & 12'hFFF;
        col_sum[c] = cs[11:0];
        line_pix[slot*1024 + c] = p;
        if (c == 0) win_sum = cs[15:0];
        else if (c < n) win_sum = win_sum + cs[15:0];
        else win_sum = win_sum + cs[15:0] - {4'b0, col_sum[c-n]};
        cur_col = c + 1;
        if (cur_col >= w) begin
            cur_col = 0;
            cur_row = r + 1;
            if (cur_row >= h) cur_row = 0;
        end
        if (r + 1 >= n && c + 1 >= n) begin
            mean = win_sum / (n * n);
            res.mean = mean[7:0];
            res.row = 10'(r + 1 - n + n / 2);
            res.col = 10'(c + 1 - n + n / 2);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic report_mismatch(string what);
        $display("tb: mismatch at cycle %0d: %s", cycle_count, what);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_window_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_means.size() == 0) begin
                report_mismatch("result with none expected");
            end else begin
                want = pending_means.pop_front();
                if (o_mean_value !== want.mean)
                    report_mismatch($sformatf("mean %0d want %0d", o_mean_value, want.mean));
                if (o_center_row !== want.row)
                    report_mismatch($sformatf("row %0d want %0d", o_center_row, want.row));
                if (o_center_col !== want.col)
                    report_mismatch($sformatf("col %0d want %0d", o_center_col, want.col));
            end
        end
    end

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // drive one request; called at a falling edge, returns at a falling edge
    task automatic send_pixel(logic [7:0] p, logic fs, logic typed, t_window_out typed_res);
        t_window_out res;
        logic        has;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_pixel <= p;
        i_frame_start <= fs | force_fs;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        has = filter_pixel(p, fs | force_fs, res);
        force_fs = 1'b0;
        if (typed) pending_means.push_back(typed_res);
        else if (has) pending_means.push_back(res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_means.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        i_cfg_idx <= REG_NONE;
        case (idx)
            REG_WINDOW_SIZE:  win_reg = data[3:0];
            REG_IMAGE_WIDTH:  width_reg = data;
            REG_IMAGE_HEIGHT: height_reg = data;
            default: ;
        endcase
    endtask

    // drain, then load all three registers and restart the frame
    task automatic set_geometry(int unsigned n, int unsigned w, int unsigned h);
        drain_results();
        write_reg(REG_WINDOW_SIZE, {7'($urandom_range(0, 127)), 4'(n)});
        write_reg(REG_IMAGE_WIDTH, CFG_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(h));
        force_fs = 1'b1;
    endtask

    task automatic send_frames(int count);
        int unsigned fsize, pos;
        logic        fs;
        fsize = clamp_to(width_reg, 1024) * clamp_to(height_reg, 1024);
        pos = 0;
        for (int k = 0; k < count; k++) begin
            fs = (pos == 0) ? $urandom_range(0, 1) : ($urandom_range(0, 99) < 3);
            if (fs) pos = 0;
            send_pixel(8'($urandom), fs, 1'b0, '0);
            pos = (pos + 1) % fsize;
        end
    endtask

    t_dir_row dir_tab [DIR_ROWS];

    initial begin
        int unsigned n, w, h;
        int          phase;
        fail_count = 0;
        items_sent = 0;
        cycle_count = 0;
        hold_left = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        force_fs = 1'b0;
        win_reg = 3;
        width_reg = 640;
        height_reg = 480;
        win_sum = '0;
        cur_row = 0;
        cur_col = 0;

        // N=1 on a 4x2 image: mean is the pixel itself
        dir_tab[0]  = '{8'd0,   1'b1, 1'b1, '{8'd0,   10'd0, 10'd0}};
        dir_tab[1]  = '{8'd255, 1'b0, 1'b1, '{8'd255, 10'd0, 10'd1}};
        dir_tab[2]  = '{8'd1,   1'b0, 1'b1, '{8'd1,   10'd0, 10'd2}};
        dir_tab[3]  = '{8'd128, 1'b0, 1'b1, '{8'd128, 10'd0, 10'd3}};
        dir_tab[4]  = '{8'd200, 1'b0, 1'b1, '{8'd200, 10'd1, 10'd0}};
        dir_tab[5]  = '{8'd7,   1'b0, 1'b1, '{8'd7,   10'd1, 10'd1}};
        dir_tab[6]  = '{8'd254, 1'b0, 1'b1, '{8'd254, 10'd1, 10'd2}};
        dir_tab[7]  = '{8'd3,   1'b0, 1'b1, '{8'd3,   10'd1, 10'd3}};
        dir_tab[8]  = '{8'd9,   1'b0, 1'b1, '{8'd9,   10'd0, 10'd0}};
        dir_tab[9]  = '{8'd77,  1'b0, 1'b1, '{8'd77,  10'd0, 10'd1}};
        dir_tab[10] = '{8'd5,   1'b1, 1'b1, '{8'd5,   10'd0, 10'd0}};
        // N=2 on a 3x3 image, checked by the model
        for (int k = DIR_SPLIT; k < DIR_ROWS; k++)
            dir_tab[k] = '{(k % 2) ? 8'd255 : 8'd0, k == DIR_SPLIT, 1'b0, '0};

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (k == 0) set_geometry(1, 4, 2);
            if (k == DIR_SPLIT) set_geometry(2, 3, 3);
            send_pixel(dir_tab[k].pixel, dir_tab[k].fs, dir_tab[k].typed, dir_tab[k].res);
        end

        // extremes: widest window, zero window, saturated size, zero size, window beyond image
        set_geometry(15, 16, 16);
        send_frames(256);
        set_geometry(0, 5, 3);
        send_frames(20);
        set_geometry(1, 2047, 2047);
        send_frames(40);
        set_geometry(1, 0, 0);
        send_frames(6);
        set_geometry(5, 3, 3);
        send_frames(12);

        // shrink width and height inside a frame without restarting it
        set_geometry(2, 9, 8);
        send_frames(40);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_W'(4));
        write_reg(REG_IMAGE_HEIGHT, CFG_W'(3));
        force_fs = 1'b0;
        send_frames(20);

        phase = 0;
        while (items_sent < 1350) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 49; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 49; end
                default: begin send_idle_pct = 9; stall_pct = 9; end
            endcase
            if ($urandom_range(0, 9) == 0) n = $urandom_range(0, 15);
            else n = $urandom_range(1, 4);
            w = $urandom_range(1, 16);
            h = $urandom_range(1, 10);
            if ($urandom_range(0, 9) == 0) w = 0;
            // pick a geometry that yields results so the long hold backs up
            if (phase == 2) begin
                n = 2;
                w = 8;
                h = 6;
            end
            set_geometry(n, w, h);
            if (phase == 2) hold_left <= 3000;  // fill the block while results back up
            send_frames($urandom_range(30, 120));
            phase++;
        end

        drain_results();
        if (fail_count == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end
endmodule
